### sv/bb_pkg.sv
package bb_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SUM_W      = 12;
  localparam int NUM_W      = 13;
  localparam int RCP_W      = 18;
  localparam int RCP_SHIFT  = 18;
  localparam int PROD_W     = NUM_W + RCP_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int HEIGHT_MAX = 4096;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MQ_DEPTH   = 4;
  localparam int OQ_DEPTH   = 8;
  localparam int WIN_N      = 9;
  localparam int CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             emit;
    logic             last;
    logic [WIN_N-1:0] mask;
  } op_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } res_t;

  function automatic logic [CNT_W-1:0] popcount9(input logic [WIN_N-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < WIN_N; k++) begin
      c = c + CNT_W'(m[k]);
    end
    return c;
  endfunction

  // ceil(2^18 / (2*count)), exact for numerators below 2^13
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] m;
    case (cnt)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

### sv/box_blur_3x3_rgb_top.sv
// 3x3 box blur over RGB frames in raster order. Beats carry a pixel or a flush; each pixel is
// replaced per channel by the rounded-half-up mean of its in-frame neighbours. The result for
// the pixel at raster index q comes out when the beat at index q+W+1 has been taken (W = frame
// width), so W+1 flush beats after the frame push out its tail; the final pixel has
// out_last_of_frame set and the next pixel beat starts a new frame. A flush before the whole
// frame has arrived is dropped; a pixel after it acts as a flush. The block sustains one beat
// per clock while results are drained: the front classifies each beat combinationally, the
// back reads both line stores as it pops a beat and writes them in the next cycle (forwarding
// when consecutive beats hit the same column), then sums, multiplies by a reciprocal and
// queues the result. The back stops popping only when eight results are already queued or
// in flight. Register writes to width or height restart the frame; all register writes must
// only be made while the block is idle; the line stores need no clearing after reset.
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_req_type,
  input  logic [bb_pkg::CH_W-1:0]       in_red,
  input  logic [bb_pkg::CH_W-1:0]       in_green,
  input  logic [bb_pkg::CH_W-1:0]       in_blue,
  output logic                          empty,
  input  logic                          pop,
  output logic [bb_pkg::CH_W-1:0]       out_red,
  output logic [bb_pkg::CH_W-1:0]       out_green,
  output logic [bb_pkg::CH_W-1:0]       out_blue,
  output logic                          out_last_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          in_fire, cfg_fire;
  logic          fq_push;
  op_t           fq_op;
  logic [CW-1:0] fq_col;
  logic          mq_empty, mq_pop;
  op_t           mq_op;
  logic [CW-1:0] mq_col;
  logic          oq_push, oq_full, oq_pop;
  res_t          oq_res, oq_head;

  assign in_fire   = push && !full;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign oq_pop    = pop && !empty;

  bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_req_type (in_req_type),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .cfg_fire    (cfg_fire),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_push      (fq_push),
    .q_op        (fq_op),
    .q_col       (fq_col)
  );

  bb_fifo #(.WIDTH($bits(op_t) + CW), .DEPTH(MQ_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   ({fq_col, fq_op}),
    .full  (full),
    .pop   (mq_pop),
    .dout  ({mq_col, mq_op}),
    .empty (mq_empty)
  );

  bb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mq_empty),
    .q_pop   (mq_pop),
    .q_op    (mq_op),
    .q_col   (mq_col),
    .oq_pop  (oq_pop),
    .oq_push (oq_push),
    .oq_res  (oq_res)
  );

  bb_fifo #(.WIDTH($bits(res_t)), .DEPTH(OQ_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_res),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_head),
    .empty (empty)
  );

  assign out_red           = oq_head.red;
  assign out_green         = oq_head.green;
  assign out_blue          = oq_head.blue;
  assign out_last_of_frame = oq_head.last;

  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(oq_push && oq_full))
    else $error("result beat pushed into a full queue");

endmodule

### sv/bb_ram.sv
module bb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bb_fifo.sv
module bb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CNTW'(do_push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### sv/bb_front.sv
module bb_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic                            in_req_type,
  input  logic [bb_pkg::CH_W-1:0]         in_red,
  input  logic [bb_pkg::CH_W-1:0]         in_green,
  input  logic [bb_pkg::CH_W-1:0]         in_blue,
  input  logic                            cfg_fire,
  input  logic [bb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                            q_push,
  output bb_pkg::op_t                     q_op,
  output logic [$clog2(MAX_WIDTH)-1:0]    q_col
);

  import bb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW-1:0]    w_eff_r, w_eff_nxt;
  logic [FH_W-1:0]  h_eff_r, h_eff_nxt;
  logic [FW_W-1:0]  w_raw;
  logic [FH_W-1:0]  h_raw;
  logic             in_frame, drop, col_first, emit, last, col_wrap;
  logic             left_ok, right_ok, top_ok, bot_ok;
  logic             cfg_restart;
  logic [CW-1:0]    qc;
  logic [ROW_W-1:0] qr;

  assign w_raw = cfg_data[FW_W-1:0];
  assign h_raw = cfg_data[FH_W-1:0];

  always_comb begin
    if (w_raw == '0) begin
      w_eff_nxt = WW'(1);
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      w_eff_nxt = WW'(MAX_WIDTH);
    end else begin
      w_eff_nxt = WW'(w_raw);
    end
    if (h_raw == '0) begin
      h_eff_nxt = FH_W'(1);
    end else if (h_raw > FH_W'(HEIGHT_MAX)) begin
      h_eff_nxt = FH_W'(HEIGHT_MAX);
    end else begin
      h_eff_nxt = h_raw;
    end
  end

  // classify the beat and locate the pixel whose window completes now
  assign in_frame  = (row_r < h_eff_r);
  assign drop      = in_frame && (in_req_type == REQ_FLUSH);
  assign col_first = (col_r == '0);
  assign emit      = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && !col_first);
  assign qc        = col_first ? CW'(w_eff_r - WW'(1)) : col_r - CW'(1);
  assign qr        = col_first ? row_r - ROW_W'(2) : row_r - ROW_W'(1);
  assign left_ok   = (qc != '0);
  assign right_ok  = (32'(qc) + 32'd1) < 32'(w_eff_r);
  assign top_ok    = (qr != '0);
  assign bot_ok    = (32'(qr) + 32'd1) < 32'(h_eff_r);
  assign last      = emit && ((32'(qr) + 32'd1) == 32'(h_eff_r))
                          && ((32'(qc) + 32'd1) == 32'(w_eff_r));
  assign col_wrap  = (32'(col_r) + 32'd1) >= 32'(w_eff_r);

  assign q_push    = in_fire && !drop;
  assign q_op.pix  = in_frame ? {in_red, in_green, in_blue} : '0;
  assign q_op.emit = emit;
  assign q_op.last = last;
  assign q_op.mask = {right_ok & bot_ok, right_ok, right_ok & top_ok,
                      bot_ok, 1'b1, top_ok,
                      left_ok & bot_ok, left_ok, left_ok & top_ok};
  assign q_col     = col_r;

  assign cfg_restart = cfg_fire &&
                       ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (q_push) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      w_eff_r <= WW'(W_RST);
      h_eff_r <= FH_W'(1);
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_fire && (cfg_index == REG_FRAME_WIDTH)) begin
        w_eff_r <= w_eff_nxt;
      end
      if (cfg_fire && (cfg_index == REG_FRAME_HEIGHT)) begin
        h_eff_r <= h_eff_nxt;
      end
    end
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(w_eff_r))
    else $error("input column beyond frame width");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_op.last) |=> ((col_r == '0) && (row_r == '0)))
    else $error("frame counters not restarted after last pixel");

endmodule

### sv/bb_back.sv
module bb_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  bb_pkg::op_t                  q_op,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  logic                         oq_pop,
  output logic                         oq_push,
  output bb_pkg::res_t                 oq_res
);

  import bb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CRW = $clog2(OQ_DEPTH + 1);

  logic [CRW-1:0]   cred_r, cred_nxt;

  logic             p1_vld_r;
  op_t              p1_op_r;
  logic [CW-1:0]    p1_col_r;
  logic             p1_byp_r;
  logic [PIX_W-1:0] fwd_up_r, fwd_lo_r;
  logic [PIX_W-1:0] up_rdata, lo_rdata, above, mid;

  logic [PIX_W-1:0] win_r [WIN_N];

  logic             p2_vld_r;
  logic [WIN_N-1:0] p2_mask_r;
  logic             p2_last_r;
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [CNT_W-1:0] cnt;

  logic             p3_vld_r;
  logic [NUM_W-1:0] p3_num_red_r, p3_num_green_r, p3_num_blue_r;
  logic [RCP_W-1:0] p3_rcp_r;
  logic             p3_last_r;
  logic [PROD_W-1:0] prod_red, prod_green, prod_blue;

  // pop only with a free output slot reserved
  assign q_pop    = !q_empty && (cred_r < CRW'(OQ_DEPTH));
  assign cred_nxt = cred_r + CRW'(q_pop && q_op.emit) - CRW'(oq_pop);

  bb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (p1_vld_r),
    .waddr (p1_col_r),
    .wdata (mid),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (up_rdata)
  );

  bb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (p1_vld_r),
    .waddr (p1_col_r),
    .wdata (p1_op_r.pix),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (lo_rdata)
  );

  // same column read while being written: take the written beat
  assign above = p1_byp_r ? fwd_up_r : up_rdata;
  assign mid   = p1_byp_r ? fwd_lo_r : lo_rdata;

  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int k = 0; k < WIN_N; k++) begin
      if (p2_mask_r[k]) begin
        sum_red   = sum_red   + SUM_W'(win_r[k][2*CH_W +: CH_W]);
        sum_green = sum_green + SUM_W'(win_r[k][CH_W +: CH_W]);
        sum_blue  = sum_blue  + SUM_W'(win_r[k][0 +: CH_W]);
      end
    end
    cnt = popcount9(p2_mask_r);
  end

  assign prod_red   = PROD_W'(p3_num_red_r)   * PROD_W'(p3_rcp_r);
  assign prod_green = PROD_W'(p3_num_green_r) * PROD_W'(p3_rcp_r);
  assign prod_blue  = PROD_W'(p3_num_blue_r)  * PROD_W'(p3_rcp_r);

  assign oq_push      = p3_vld_r;
  assign oq_res.red   = prod_red[RCP_SHIFT +: CH_W];
  assign oq_res.green = prod_green[RCP_SHIFT +: CH_W];
  assign oq_res.blue  = prod_blue[RCP_SHIFT +: CH_W];
  assign oq_res.last  = p3_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r   <= '0;
      p1_vld_r <= 1'b0;
      p1_byp_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      cred_r   <= cred_nxt;
      p1_vld_r <= q_pop;
      p1_byp_r <= q_pop && p1_vld_r && (q_col == p1_col_r);
      p2_vld_r <= p1_vld_r && p1_op_r.emit;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_N; k++) begin
        win_r[k] <= '0;
      end
    end else if (p1_vld_r) begin
      for (int k = 0; k < WIN_N - 3; k++) begin
        win_r[k] <= win_r[k+3];
      end
      win_r[WIN_N-3] <= above;
      win_r[WIN_N-2] <= mid;
      win_r[WIN_N-1] <= p1_op_r.pix;
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r        <= q_op;
    p1_col_r       <= q_col;
    fwd_up_r       <= mid;
    fwd_lo_r       <= p1_op_r.pix;
    p2_mask_r      <= p1_op_r.mask;
    p2_last_r      <= p1_op_r.last;
    p3_num_red_r   <= NUM_W'({sum_red, 1'b0})   + NUM_W'(cnt);
    p3_num_green_r <= NUM_W'({sum_green, 1'b0}) + NUM_W'(cnt);
    p3_num_blue_r  <= NUM_W'({sum_blue, 1'b0})  + NUM_W'(cnt);
    p3_rcp_r       <= recip(cnt);
    p3_last_r      <= p2_last_r;
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CRW'(OQ_DEPTH))
    else $error("output credit count overflow");

  a_push_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (cred_r != '0))
    else $error("result pushed without a reserved slot");

  a_bypass_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    p1_byp_r |-> $past(p1_vld_r))
    else $error("line store forward without a write in flight");

endmodule

### test/box_blur_3x3_rgb_top_tb.sv
module box_blur_3x3_rgb_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bb_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 420;
  localparam int REPORT_MAX    = 10;
  localparam int DIR_N         = 21;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic             req;
    logic [PIX_W-1:0] pix;
    logic             typed;
    res_t             want;
  } beat_t;

  localparam logic [25:0] NO_RES    = '0;
  localparam logic [25:0] WHITE_MID = {1'b1, 8'd255, 8'd255, 8'd255, 1'b0};
  localparam logic [25:0] WHITE_END = {1'b1, 8'd255, 8'd255, 8'd255, 1'b1};

  // 3x2 frame: all white with an early flush, then a mixed frame ended by stray pixels and flushes
  localparam beat_t DIRECTED [DIR_N] = '{
    {REQ_PIXEL, 24'hFFFFFF, NO_RES},
    {REQ_PIXEL, 24'hFFFFFF, NO_RES},
    {REQ_PIXEL, 24'hFFFFFF, NO_RES},
    {REQ_PIXEL, 24'hFFFFFF, NO_RES},
    {REQ_FLUSH, 24'hFFFFFF, NO_RES},
    {REQ_PIXEL, 24'hFFFFFF, WHITE_MID},
    {REQ_PIXEL, 24'hFFFFFF, WHITE_MID},
    {REQ_FLUSH, 24'h000000, WHITE_MID},
    {REQ_FLUSH, 24'h000000, WHITE_MID},
    {REQ_FLUSH, 24'h000000, WHITE_MID},
    {REQ_FLUSH, 24'h000000, WHITE_END},
    {REQ_PIXEL, 24'h000000, NO_RES},
    {REQ_PIXEL, 24'hFFFFFF, NO_RES},
    {REQ_PIXEL, 24'hFF0000, NO_RES},
    {REQ_PIXEL, 24'h00FF00, NO_RES},
    {REQ_PIXEL, 24'h0000FF, NO_RES},
    {REQ_PIXEL, 24'h7F8001, NO_RES},
    {REQ_PIXEL, 24'hFFFFFF, NO_RES},
    {REQ_PIXEL, 24'h000000, NO_RES},
    {REQ_FLUSH, 24'h000000, NO_RES},
    {REQ_FLUSH, 24'hFFFFFF, NO_RES}
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  logic                  in_req_type = 1'b0;
  logic [CH_W-1:0]       in_red      = '0;
  logic [CH_W-1:0]       in_green    = '0;
  logic [CH_W-1:0]       in_blue     = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  out_last_of_frame;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  box_blur_3x3_rgb_top #(.MAX_WIDTH(MAX_W)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_req_type       (in_req_type),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .empty             (empty),
    .pop               (pop),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // blur model state
  logic [FW_W-1:0]  blur_width_reg  = FW_W'(1024);
  logic [FH_W-1:0]  blur_height_reg = FH_W'(1);
  logic [PIX_W-1:0] upper_line [MAX_W];
  logic [PIX_W-1:0] lower_line [MAX_W];
  logic [PIX_W-1:0] window_px [WIN_N];
  int               col_pos;
  int               row_pos;

  beat_t stim_q [$];
  res_t  blur_q [$];

  int burst_left    = 0;
  int gap_left      = 0;
  bit sender_quiet  = 1'b0;
  bit pop_hold      = 1'b1;
  int pop_run       = 0;
  int quiet_cycles  = 0;
  int fail_count    = 0;
  int beats_in      = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int counted_items = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int frame_w();
    if (blur_width_reg == 0) return 1;
    if (blur_width_reg > MAX_W) return MAX_W;
    return int'(blur_width_reg);
  endfunction

  function automatic int frame_h();
    if (blur_height_reg == 0) return 1;
    if (blur_height_reg > HEIGHT_MAX) return HEIGHT_MAX;
    return int'(blur_height_reg);
  endfunction

  function automatic void blur_restart();
    for (int k = 0; k < WIN_N; k++) window_px[k] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void predict_blur(input logic req, input logic [PIX_W-1:0] data,
                                       output logic hit, output res_t r);
    int w, h, ac, ar, qc, qr, nc, nr, cnt, sum_r, sum_g, sum_b;
    logic [PIX_W-1:0] px, above, mid, v;
    w = frame_w();
    h = frame_h();
    hit = 1'b0;
    r = '0;
    px = '0;
    ac = col_pos;
    ar = row_pos;
    if (row_pos * w + col_pos < w * h) begin
      if (req == REQ_FLUSH) return;
      px = data;
    end
    above = upper_line[ac];
    mid = lower_line[ac];
    upper_line[ac] = mid;
    lower_line[ac] = px;
    for (int s = 0; s < 6; s++) window_px[s] = window_px[s + 3];
    window_px[6] = above;
    window_px[7] = mid;
    window_px[8] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!(ar >= 2 || (ar == 1 && ac >= 1))) return;
    if (ac >= 1) begin
      qc = ac - 1;
      qr = ar - 1;
    end else begin
      qc = w - 1;
      qr = ar - 2;
    end
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt = 0;
    for (int s = 0; s < 3; s++) begin
      nc = qc - 1 + s;
      if (nc >= 0 && nc < w) begin
        for (int t = 0; t < 3; t++) begin
          nr = qr - 1 + t;
          if (nr >= 0 && nr < h) begin
            v = window_px[s * 3 + t];
            sum_r += v[23:16];
            sum_g += v[15:8];
            sum_b += v[7:0];
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    hit = 1'b1;
    r.red   = CH_W'((2 * sum_r + cnt) / (2 * cnt));
    r.green = CH_W'((2 * sum_g + cnt) / (2 * cnt));
    r.blue  = CH_W'((2 * sum_b + cnt) / (2 * cnt));
    r.last  = (qr == h - 1) && (qc == w - 1);
    if (r.last) blur_restart();
  endfunction

  task automatic note_failure(input string what, input res_t want, input res_t got);
    if (fail_count < REPORT_MAX)
      $display({"%s at result %0d: expected r=%0d g=%0d b=%0d last=%0b,",
                " got r=%0d g=%0d b=%0d last=%0b"},
               what, results_seen, want.red, want.green, want.blue, want.last,
               got.red, got.green, got.blue, got.last);
    fail_count++;
  endtask

  // input side: bursts and gaps
  always @(posedge clk) begin : feed
    beat_t head;
    res_t  pred;
    logic  hit;
    logic  took;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      took = push && !full;
      if (took) begin
        head = stim_q.pop_front();
        predict_blur(head.req, head.pix, hit, pred);
        if (hit) blur_q.push_back(head.typed ? head.want : pred);
        beats_in++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (sender_quiet) gap_left = 0;
          else if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(6, 12);
          else gap_left = $urandom_range(0, 3);
        end
      end
      if (push && !took) begin
        push <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (stim_q.size() != 0) begin
        push        <= 1'b1;
        in_req_type <= stim_q[0].req;
        in_red      <= stim_q[0].pix[23:16];
        in_green    <= stim_q[0].pix[15:8];
        in_blue     <= stim_q[0].pix[7:0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side: on and off runs
  always @(posedge clk) begin : drain
    res_t got;
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        got.last  = out_last_of_frame;
        if (blur_q.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = blur_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last)
            note_failure("mismatch", want, got);
        end
        results_seen++;
      end
      if (pop_run == 0) begin
        pop_hold = ($urandom_range(0, 2) != 0);
        pop_run = pop_hold ? $urandom_range(1, 40) : $urandom_range(1, 8);
      end
      pop_run--;
      pop <= pop_hold;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("no beat for %0d cycles, %0d results outstanding", STALL_LIMIT, blur_q.size());
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      blur_width_reg = val[FW_W-1:0];
      blur_restart();
    end else if (idx == REG_FRAME_HEIGHT) begin
      blur_height_reg = val[FH_W-1:0];
      blur_restart();
    end
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic settle();
    do @(negedge clk); while (stim_q.size() != 0 || push || blur_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic queue_beat(input logic req, input logic [PIX_W-1:0] px);
    beat_t b;
    b = '0;
    b.req = req;
    b.pix = px;
    stim_q.push_back(b);
  endtask

  // pixels of a frame, with stray early flushes mixed in
  task automatic queue_pixels(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        queue_beat(REQ_FLUSH, {rand_chan(), rand_chan(), rand_chan()});
      queue_beat(REQ_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
      counted_items++;
    end
  endtask

  // beats after the frame; pixels here act as flushes
  task automatic queue_tail(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_beat(REQ_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
      else
        queue_beat(REQ_FLUSH, {rand_chan(), rand_chan(), rand_chan()});
      counted_items++;
    end
  endtask

  task automatic queue_frame(input int noise_pct);
    queue_pixels(frame_w() * frame_h(), noise_pct);
    queue_tail(frame_w() + 1);
  endtask

  task automatic run_setting(input logic [CFG_DATA_W-1:0] w_raw,
                             input logic [CFG_DATA_W-1:0] h_raw,
                             input int frames, input int noise_pct);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_FRAME_WIDTH, w_raw);
      write_reg(REG_FRAME_HEIGHT, h_raw);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h_raw);
      write_reg(REG_FRAME_WIDTH, w_raw);
    end
    sender_quiet = ($urandom_range(0, 3) == 0);
    for (int f = 0; f < frames; f++) queue_frame(noise_pct);
  endtask

  initial begin : run
    int base;
    int w;
    int h;
    logic [CFG_DATA_W-1:0] w_raw;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    blur_restart();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes: start of one row of 1024
    queue_pixels(40, 5);
    settle();

    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    for (int i = 0; i < DIR_N; i++) stim_q.push_back(DIRECTED[i]);
    settle();

    // out of range sizes and one-pixel frames
    run_setting(CFG_DATA_W'(0), CFG_DATA_W'(0), 2, 20);
    settle();
    run_setting(CFG_DATA_W'(13'h1FFF), CFG_DATA_W'(1), 0, 0);
    queue_pixels(30, 2);
    settle();
    run_setting(CFG_DATA_W'(1), CFG_DATA_W'(13'h1FFF), 0, 0);
    queue_pixels(40, 1);
    settle();
    run_setting(CFG_DATA_W'(1), CFG_DATA_W'(1), 3, 30);
    settle();
    run_setting(CFG_DATA_W'(1), CFG_DATA_W'(2), 2, 10);
    settle();
    run_setting(CFG_DATA_W'(2), CFG_DATA_W'(1), 2, 10);
    settle();

    // unused index mid-frame must not restart
    run_setting(CFG_DATA_W'(4), CFG_DATA_W'(3), 0, 0);
    queue_pixels(6, 10);
    settle();
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CFG_DATA_W'($urandom));
    queue_pixels(6, 10);
    queue_tail(5);
    settle();

    base = counted_items;
    while (counted_items - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       w = 1;
        1:       w = 2;
        2:       w = $urandom_range(9, 24);
        default: w = $urandom_range(3, 8);
      endcase
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      w_raw = CFG_DATA_W'(w) | CFG_DATA_W'($urandom_range(0, 3) << FW_W);
      run_setting(w_raw, CFG_DATA_W'(h), (w * h > 60) ? 1 : $urandom_range(1, 3),
                  $urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0)
        queue_pixels($urandom_range(1, w * h), $urandom_range(0, 15));
      settle();
    end

    $display("covered %0d input beats and %0d results over %0d register writes,",
             beats_in, results_seen, cfg_writes);
    $display("frames up to 24 wide, clamped sizes and cut-off frames, %0d failures",
             fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
